### hw/rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int NumLevels = 8;
  localparam int Units = 1 << (NumLevels - 1);
  localparam int OffW = 7;
  localparam int OrdW = 3;
  localparam int MinBlockBytes = 64;
  localparam int MinShift = 6;
  localparam int FreeDepth = 2 * Units;
  localparam int FreeAw = OffW + 1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;
  localparam logic [3:0] LEVELS_RESET = 4'd8;

  function automatic logic [FreeAw-1:0] fidx(input logic [OrdW-1:0] o,
                                               input logic [OffW-1:0] p);
    logic [FreeAw-1:0] base;
    base = FreeAw'(Units >> o);
    fidx = FreeAw'(base + FreeAw'(p >> o));
  endfunction
endpackage
`default_nettype wire

### hw/rtl/bba_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface bba_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [15:0] size_bytes;
  logic [6:0] block_offset;
  modport source(output valid, req_type, size_bytes, block_offset, input ready);
  modport sink(input valid, req_type, size_bytes, block_offset, output ready);
endinterface

interface bba_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [6:0] granted_offset;
  logic [2:0] granted_order;
  modport source(output valid, status, granted_offset, granted_order, input ready);
  modport sink(input valid, status, granted_offset, granted_order, output ready);
endinterface
`default_nettype wire

### hw/rtl/bba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// oversize alloc or out-of-region free goes from idle straight to the result state
// alloc: SCAN then SCHK per free-map probe, up to 255 probes, then one SPLIT per split
// free: order read (TWAIT), block check (FRD, FCHK), then BRD and BCHK per buddy probe
// one request in flight; the next input is taken the cycle after the result transfer
// reset and every levels_in_use write start a clearing pass over all 256 free-map entries
// no transfer is taken during the pass; order table is not cleared
module buddy_block_allocator (
  input  wire logic clk,
  input  wire logic rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW = bba_pkg::FreeAw;
  localparam int OW = bba_pkg::OffW;
  localparam int RW = bba_pkg::OrdW;
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2, S_SCHK = 4'd3,
    S_SPLIT = 4'd4, S_FRD = 4'd5, S_FCHK = 4'd6, S_BRD = 4'd7, S_BCHK = 4'd8,
    S_OUT = 4'd9, S_TWAIT = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [3:0] lv_r;
  logic [AW:0] clr_r, clr_nxt;
  logic [RW-1:0] t;
  logic [RW-1:0] o_r, o_nxt, i_r, i_nxt;
  logic [OW:0] p_r, p_nxt;
  logic [1:0] so_r, so_nxt;
  logic [OW-1:0] go_r, go_nxt;
  logic [RW-1:0] gr_r, gr_nxt;

  logic fwe, fwd, frd;
  logic [AW-1:0] fwa, fra;
  logic twe;
  logic [OW-1:0] twa, tra;
  logic [RW-1:0] twd, trd;

  bba_ram #(.Width(1), .Depth(bba_pkg::FreeDepth)) u_free (
    .clk, .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd));
  bba_ram #(.Width(RW), .Depth(bba_pkg::Units)) u_ord (
    .clk, .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd));

  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {28'd0, lv_r} : 32'd0;

  always_comb begin
    if (lv_r == 4'd0) t = '0;
    else if (lv_r > 4'(bba_pkg::NumLevels)) t = RW'(bba_pkg::NumLevels - 1);
    else t = RW'(lv_r - 4'd1);
  end

  wire [OW:0] units = (OW+1)'(1) << t;
  wire [16:0] need = (in_ch.size_bytes < 16'(bba_pkg::MinBlockBytes)) ?
                     17'(bba_pkg::MinBlockBytes) : {1'b0, in_ch.size_bytes};
  wire [16:0] nm1 = (need - 17'd1) >> bba_pkg::MinShift;
  logic [RW:0] ord_in;
  always_comb begin
    ord_in = '0;
    for (int k = 0; k < 11; k++) if (nm1[k]) ord_in = (RW+1)'(k + 1);
  end
  wire oversize = (ord_in > {1'b0, t});
  wire [RW-1:0] o_clamp = (trd > t) ? t : trd;
  wire [OW:0] step = (OW+1)'(1) << i_r;
  wire [OW-1:0] bud = p_r[OW-1:0] ^ (OW'(1) << o_r);

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.status = so_r;
  assign out_ch.granted_offset = go_r;
  assign out_ch.granted_order = gr_r;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; o_nxt = o_r; i_nxt = i_r; p_nxt = p_r;
    so_nxt = so_r; go_nxt = go_r; gr_nxt = gr_r;
    fwe = 1'b0; fwa = '0; fwd = 1'b0; fra = '0;
    twe = 1'b0; twa = '0; twd = '0; tra = in_ch.block_offset;
    unique case (st_r)
      S_CLR: begin
        fwe = 1'b1; fwa = clr_r[AW-1:0];
        fwd = (clr_r[AW-1:0] == bba_pkg::fidx(t, '0));
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(bba_pkg::FreeDepth - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          go_nxt = '0; gr_nxt = '0; so_nxt = bba_pkg::ST_OK;
          if (in_ch.req_type == bba_pkg::REQ_ALLOC) begin
            if (oversize) begin
              so_nxt = bba_pkg::ST_OVER; st_nxt = S_OUT;
            end else begin
              o_nxt = ord_in[RW-1:0]; i_nxt = ord_in[RW-1:0]; p_nxt = '0;
              st_nxt = S_SCAN;
            end
          end else if ({1'b0, in_ch.block_offset} >= units) begin
            st_nxt = S_OUT;
          end else begin
            go_nxt = in_ch.block_offset;
            st_nxt = S_TWAIT;
          end
        end
      end
      S_TWAIT: begin
        o_nxt = o_clamp; gr_nxt = o_clamp;
        p_nxt = {1'b0, go_r & ~((OW'(1) << o_clamp) - OW'(1))};
        st_nxt = S_FRD;
      end
      S_SCAN: begin
        fra = bba_pkg::fidx(i_r, p_r[OW-1:0]);
        st_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (frd) begin
          fwe = 1'b1; fwa = bba_pkg::fidx(i_r, p_r[OW-1:0]); fwd = 1'b0;
          st_nxt = (i_r == o_r) ? S_OUT : S_SPLIT;
          go_nxt = p_r[OW-1:0]; gr_nxt = o_r;
          if (i_r == o_r) begin
            twe = 1'b1; twa = p_r[OW-1:0]; twd = o_r;
          end
        end else if (p_r + step < units) begin
          p_nxt = p_r + step; st_nxt = S_SCAN;
        end else if (i_r < t) begin
          i_nxt = i_r + 1'b1; p_nxt = '0; st_nxt = S_SCAN;
        end else begin
          so_nxt = bba_pkg::ST_NOBLK; gr_nxt = o_r; st_nxt = S_OUT;
        end
      end
      S_SPLIT: begin
        fwe = 1'b1; fwd = 1'b1;
        fwa = bba_pkg::fidx(i_r - 1'b1, p_r[OW-1:0] | (OW'(1) << (i_r - 1'b1)));
        i_nxt = i_r - 1'b1;
        if (i_r - 1'b1 == o_r) begin
          twe = 1'b1; twa = p_r[OW-1:0]; twd = o_r; st_nxt = S_OUT;
        end
      end
      S_FRD: begin
        fra = bba_pkg::fidx(o_r, p_r[OW-1:0]);
        st_nxt = S_FCHK;
      end
      S_FCHK: begin
        st_nxt = frd ? S_OUT : S_BRD;
      end
      S_BRD: begin
        if (o_r < t) begin
          fra = bba_pkg::fidx(o_r, bud);
          st_nxt = S_BCHK;
        end else begin
          fwe = 1'b1; fwa = bba_pkg::fidx(o_r, p_r[OW-1:0]); fwd = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_BCHK: begin
        if (frd) begin
          fwe = 1'b1; fwa = bba_pkg::fidx(o_r, bud); fwd = 1'b0;
          p_nxt = {1'b0, p_r[OW-1:0] & bud};
          o_nxt = o_r + 1'b1; st_nxt = S_BRD;
        end else begin
          fwe = 1'b1; fwa = bba_pkg::fidx(o_r, p_r[OW-1:0]); fwd = 1'b1;
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_wr && cfg_paddr == 1'b0) begin
      st_nxt = S_CLR; clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; lv_r <= bba_pkg::LEVELS_RESET;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt;
      if (cfg_wr && cfg_paddr == 1'b0) lv_r <= cfg_pwdata[3:0];
    end
    o_r <= o_nxt; i_r <= i_nxt; p_r <= p_nxt;
    so_r <= so_nxt; go_r <= go_nxt; gr_r <= gr_nxt;
  end
endmodule
`default_nettype wire

### tb/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
module tb_buddy_block_allocator;

  typedef struct {
    logic                     req_type;
    logic [15:0]              size_bytes;
    logic [bba_pkg::OffW-1:0] block_offset;
  } request_t;

  typedef struct {
    logic [1:0]               status;
    logic [bba_pkg::OffW-1:0] granted_offset;
    logic [bba_pkg::OrdW-1:0] granted_order;
  } grant_t;

  class AllocScoreboard;
    bit                     free_bits[bba_pkg::NumLevels][bba_pkg::Units];
    bit [bba_pkg::OrdW-1:0] order_of[bba_pkg::Units];
    bit                     recorded[bba_pkg::Units];
    int            levels;
    grant_t        pending_grants[$];
    int            errors;
    int            checked;
    int            n_alloc_ok;
    int            n_noblk;
    int            n_over;
    int            n_free;

    function new();
      levels = bba_pkg::LEVELS_RESET;
      errors = 0;
      checked = 0;
      n_alloc_ok = 0;
      n_noblk = 0;
      n_over = 0;
      n_free = 0;
      foreach (recorded[i]) recorded[i] = 0;
      clear_region();
    endfunction

    function int top_order();
      int l;
      l = levels;
      if (l < 1) l = 1;
      if (l > bba_pkg::NumLevels) l = bba_pkg::NumLevels;
      return l - 1;
    endfunction

    function void clear_region();
      foreach (free_bits[o, p]) free_bits[o][p] = 0;
      free_bits[top_order()][0] = 1;
    endfunction

    function void set_levels(logic [3:0] v);
      levels = v;
      clear_region();
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // note an accepted request and queue the grant it must produce
    function grant_t note_request(request_t r);
      grant_t g;
      int t, units, need, o, i, p, b;
      bit found;
      t = top_order();
      units = 1 << t;
      g.status = bba_pkg::ST_OK;
      g.granted_offset = '0;
      g.granted_order = '0;
      found = 0;
      if (r.req_type == bba_pkg::REQ_ALLOC) begin
        need = (r.size_bytes < bba_pkg::MinBlockBytes) ? bba_pkg::MinBlockBytes :
               int'(r.size_bytes);
        if (need > (bba_pkg::MinBlockBytes << t)) begin
          g.status = bba_pkg::ST_OVER;
          n_over++;
        end else begin
          o = 0;
          while ((bba_pkg::MinBlockBytes << o) < need) o++;
          p = 0;
          for (i = o; i <= t && !found; i++) begin
            for (p = 0; p < units; p += (1 << i)) begin
              if (free_bits[i][p]) begin
                found = 1;
                break;
              end
            end
            if (found) break;
          end
          if (!found) begin
            g.status = bba_pkg::ST_NOBLK;
            g.granted_order = bba_pkg::OrdW'(o);
            n_noblk++;
          end else begin
            free_bits[i][p] = 0;
            while (i > o) begin
              i--;
              free_bits[i][p + (1 << i)] = 1;
            end
            order_of[p] = bba_pkg::OrdW'(o);
            recorded[p] = 1;
            g.granted_offset = bba_pkg::OffW'(p);
            g.granted_order = bba_pkg::OrdW'(o);
            n_alloc_ok++;
          end
        end
      end else if (int'(r.block_offset) < units) begin
        n_free++;
        o = order_of[r.block_offset];
        if (o > t) o = t;
        p = int'(r.block_offset) & ~((1 << o) - 1);
        g.granted_offset = r.block_offset;
        g.granted_order = bba_pkg::OrdW'(o);
        if (!free_bits[o][p]) begin
          while (o < t) begin
            b = p ^ (1 << o);
            if (!free_bits[o][b]) break;
            free_bits[o][b] = 0;
            p &= b;
            o++;
          end
          free_bits[o][p] = 1;
        end
      end
      pending_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0d order=%0d",
                 $time, got.status, got.granted_offset, got.granted_order);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.granted_offset !== want.granted_offset) begin
        $display("%0t: granted_offset expected %0d actual %0d", $time,
                 want.granted_offset, got.granted_offset);
        errors++;
      end
      if (got.granted_order !== want.granted_order) begin
        $display("%0t: granted_order expected %0d actual %0d", $time,
                 want.granted_order, got.granted_order);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bba_in_if  in_ch();
  bba_out_if out_ch();

  buddy_block_allocator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  AllocScoreboard sb;
  int  live_offsets[$];
  bit  rx_hold;
  bit  tx_burst;
  bit  rx_burst;
  int  n_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  // result side
  initial begin
    int     stall;
    grant_t got;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        rx_hold = 0;
      end
      if ($urandom_range(0, 99) < 3) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = out_ch.status;
      got.granted_offset = out_ch.granted_offset;
      got.granted_order = out_ch.granted_order;
      sb.check_grant(got);
    end
  end

  task automatic send(request_t r);
    int     gap;
    grant_t g;
    int     k;
    if ($urandom_range(0, 99) < 3) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.req_type = r.req_type;
    in_ch.size_bytes = r.size_bytes;
    in_ch.block_offset = r.block_offset;
    do @(posedge clk); while (!in_ch.ready);
    g = sb.note_request(r);
    n_sent++;
    if (r.req_type == bba_pkg::REQ_ALLOC && g.status == bba_pkg::ST_OK) begin
      live_offsets.push_back(int'(g.granted_offset));
    end else if (r.req_type == bba_pkg::REQ_FREE) begin
      for (k = live_offsets.size() - 1; k >= 0; k--)
        if (live_offsets[k] == int'(r.block_offset)) live_offsets.delete(k);
    end
  endtask

  task automatic alloc(int size);
    request_t r;
    r.req_type = bba_pkg::REQ_ALLOC;
    r.size_bytes = 16'(size);
    r.block_offset = 7'($urandom);
    send(r);
  endtask

  task automatic release_block(int off);
    request_t r;
    r.req_type = bba_pkg::REQ_FREE;
    r.size_bytes = 16'($urandom);
    r.block_offset = bba_pkg::OffW'(off);
    send(r);
  endtask

  function automatic int stale_offset();
    int k;
    for (k = 0; k < 20; k++) begin
      int c;
      c = $urandom_range(0, bba_pkg::Units - 1);
      if (sb.recorded[c]) return c;
    end
    return -1;
  endfunction

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [3:0] v);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = '0;
    cfg_pwdata = {28'($urandom), v};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    sb.set_levels(v);
    live_offsets.delete();
  endtask

  task automatic directed_part();
    int t, k, s;
    t = sb.top_order();
    alloc(0);
    alloc(bba_pkg::MinBlockBytes);
    alloc(bba_pkg::MinBlockBytes + 1);
    alloc(16'hffff);
    alloc(bba_pkg::MinBlockBytes << t);
    alloc((bba_pkg::MinBlockBytes << t) + 1);
    for (k = 0; k < 6; k++) alloc($urandom_range(1, bba_pkg::MinBlockBytes << t));
    if (t < 7 || sb.recorded[127]) release_block(127);
    if (t < 7) release_block($urandom_range(1 << t, 127));
    if (live_offsets.size() > 0) begin
      k = live_offsets[0];
      release_block(k);
      release_block(k);
    end
    s = stale_offset();
    if (s >= 0) release_block(s);
    while (live_offsets.size() > 0) release_block(live_offsets[0]);
  endtask

  task automatic random_part(int count);
    int n, sel, t, k;
    for (n = 0; n < count; n++) begin
      t = sb.top_order();
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        alloc($urandom_range(0, 65535));
      end else if (sel < 50 || (sel < 85 && live_offsets.size() == 0)) begin
        alloc($urandom_range(0, bba_pkg::MinBlockBytes << $urandom_range(0, t)));
      end else if (sel < 85) begin
        k = $urandom_range(0, live_offsets.size() - 1);
        release_block(live_offsets[k]);
      end else if (sel < 94 || t == 7) begin
        k = stale_offset();
        if (k >= 0) release_block(k);
        else alloc(0);
      end else begin
        release_block($urandom_range(1 << t, 127));
      end
    end
  endtask

  initial begin
    logic [3:0] phase_levels[7];
    int p, limit;
    phase_levels = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8};
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = bba_pkg::REQ_ALLOC;
    in_ch.size_bytes = '0;
    in_ch.block_offset = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    rx_hold = 0;
    tx_burst = 0;
    rx_burst = 0;
    n_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain();
        cfg_write(phase_levels[p]);
      end
      directed_part();
      if (p == 2) rx_hold = 1;
      random_part(100);
      if (p == 4) drain();
      random_part(100);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
    limit = 0;
    while (sb.pending() > 0 && limit < 200000) begin
      @(posedge clk);
      limit++;
    end
    repeat (50) @(posedge clk);
    $display("sent %0d requests over 7 level settings: %0d grants, %0d frees",
             n_sent, sb.n_alloc_ok, sb.n_free);
    $display("no-block %0d, oversize %0d, results checked %0d",
             sb.n_noblk, sb.n_over, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
